[src/bslr_pkg.sv]
// Shared constants, register codes and controller/datapath link types for the blink scheduler.
package bslr_pkg;

  // Lid travel from fully open to fully closed
  localparam int unsigned FULL_SCALE = 1000;

  // Register reset values
  localparam logic [15:0] BASE_RESET   = 16'd3500;
  localparam logic [15:0] SPREAD_RESET = 16'd4001;
  localparam logic [9:0]  HALF_RESET   = 10'd90;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_SPREAD = 2'd1;
  localparam logic [1:0] REG_HALF   = 2'd2;

  // Input kinds
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_TRIGGER = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // latch the input beat
    logic div_hash;     // start hash modulo spread
    logic div_up;       // start closing ramp division
    logic div_down;     // start opening ramp division
    logic sched_wr;     // write next blink time, mark scheduled
    logic start_blink;  // activate blink at the latched time
    logic end_blink;    // end blink, open lid, reschedule
    logic lid_wr;       // load lid from the ramp quotient
    logic lid_zero;     // force lid open
    logic out_wr;       // load the result register
  } bslr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic req;          // latched beat is a trigger
    logic scheduled;
    logic active;
    logic now_ge_next;
    logic t_ge_2half;
    logic t_le_half;
    logic div_done;
    logic out_busy;     // result register full and not taken this cycle
  } bslr_sts_t;

endpackage

[src/bslr_div.sv]
// Restoring radix-2 divider: 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
module bslr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [15:0] rem
);

  localparam int DW = 32;
  localparam int CW = $clog2(DW);

  logic [DW-1:0] quot_r, quot_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [15:0]   dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [16:0]   rem_sh;
  logic [16:0]   rem_sub;
  logic          fits;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign rem_sh  = {rem_r, quot_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign fits    = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(DW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[DW-2:0], fits};
      rem_nxt  = fits ? rem_sub[15:0] : rem_sh[15:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

[src/bslr_dp.sv]
// Datapath: blink state, time compares, hash, ramp operands, shared divider and result register.
module bslr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  bslr_pkg::bslr_cmd_t cmd,
  output bslr_pkg::bslr_sts_t sts,
  input  logic                in_req,
  input  logic [31:0]         in_now,
  input  logic [15:0]         cfg_base,
  input  logic [15:0]         cfg_spread,
  input  logic [9:0]          cfg_half,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [15:0]         out_data
);

  import bslr_pkg::*;

  localparam logic [9:0] FULL = 10'(FULL_SCALE);

  // Latched beat
  logic        req_r;
  logic [31:0] now_r;
  logic [9:0]  prev_lid_r;

  // Blink state
  logic [31:0] next_r, next_nxt;
  logic [31:0] start_r, start_nxt;
  logic        active_r, active_nxt;
  logic [9:0]  lid_r, lid_nxt;
  logic        sched_r, sched_nxt;
  logic        down_r;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r;

  // Arithmetic
  logic [31:0] x1, x2, x3;
  logic [31:0] t;
  logic [31:0] u;
  logic [19:0] ramp_prod;
  logic [15:0] extra;
  logic [31:0] next_calc;
  logic [9:0]  lid_ramp;
  logic        div_start;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [31:0] div_quot;
  logic [15:0] div_rem;

  // Xorshift hash of the latched time
  assign x1 = now_r ^ (now_r << 13);
  assign x2 = x1 ^ (x1 >> 17);
  assign x3 = x2 ^ (x2 << 5);

  // Time into the blink and ramp operand
  assign t         = now_r - start_r;
  assign u         = t - {22'd0, cfg_half};
  assign ramp_prod = (cmd.div_down ? u[9:0] : t[9:0]) * FULL;

  // Divider operand selection
  assign div_start    = cmd.div_hash | cmd.div_up | cmd.div_down;
  assign div_dividend = cmd.div_hash ? x3 : {12'd0, ramp_prod};
  assign div_divisor  = cmd.div_hash ? cfg_spread : {6'd0, cfg_half};

  bslr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Next blink time; zero spread adds nothing
  assign extra     = (cfg_spread == '0) ? 16'd0 : div_rem;
  assign next_calc = now_r + {16'd0, cfg_base} + {16'd0, extra};

  // Clamp closing ramp, mirror opening ramp
  always_comb begin
    if (down_r) begin
      lid_ramp = (div_quot >= {22'd0, FULL}) ? 10'd0 : FULL - div_quot[9:0];
    end else begin
      lid_ramp = (div_quot > {22'd0, FULL}) ? FULL : div_quot[9:0];
    end
  end

  // State updates
  always_comb begin
    next_nxt      = next_r;
    start_nxt     = start_r;
    active_nxt    = active_r;
    lid_nxt       = lid_r;
    sched_nxt     = sched_r;
    out_valid_nxt = out_valid_r;
    if (cmd.sched_wr) begin
      next_nxt  = next_calc;
      sched_nxt = 1'b1;
    end
    if (cmd.start_blink) begin
      active_nxt = 1'b1;
      start_nxt  = now_r;
    end
    if (cmd.end_blink) begin
      active_nxt = 1'b0;
      lid_nxt    = '0;
      next_nxt   = next_calc;
    end
    if (cmd.lid_wr) begin
      lid_nxt = lid_ramp;
    end
    if (cmd.lid_zero) begin
      lid_nxt = '0;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_wr) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r      <= '0;
      start_r     <= '0;
      active_r    <= 1'b0;
      lid_r       <= '0;
      sched_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      next_r      <= next_nxt;
      start_r     <= start_nxt;
      active_r    <= active_nxt;
      lid_r       <= lid_nxt;
      sched_r     <= sched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold beat fields, ramp direction and the result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= in_req;
      now_r      <= in_now;
      prev_lid_r <= lid_r;
    end
    if (cmd.div_up || cmd.div_down) begin
      down_r <= cmd.div_down;
    end
    if (cmd.out_wr) begin
      out_data_r <= {4'd0, active_r, (lid_r != prev_lid_r), lid_r};
    end
  end

  // Status back to the controller
  always_comb begin
    sts.req         = (req_r == REQ_TRIGGER);
    sts.scheduled   = sched_r;
    sts.active      = active_r;
    sts.now_ge_next = now_r >= next_r;
    sts.t_ge_2half  = t >= {21'd0, cfg_half, 1'b0};
    sts.t_le_half   = t <= {22'd0, cfg_half};
    sts.div_done    = div_done;
    sts.out_busy    = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/bslr_ctrl.sv]
// Controller: sequences one beat through scheduling, blink start, ramp or end, and result.
module bslr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bslr_pkg::bslr_sts_t sts,
  output bslr_pkg::bslr_cmd_t cmd
);

  import bslr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCHED  = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_END    = 3'd5;
  localparam logic [2:0] S_RAMP   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      // Trigger starts a blink if none runs; a tick schedules first if needed
      S_DECODE: begin
        if (sts.req) begin
          cmd.start_blink = !sts.active;
          state_nxt       = S_OUT;
        end else if (!sts.scheduled) begin
          cmd.div_hash = 1'b1;
          state_nxt    = S_SCHED;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_SCHED: begin
        if (sts.div_done) begin
          cmd.sched_wr = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      // Start a blink when its time has come
      S_CHECK: begin
        cmd.start_blink = !sts.active && sts.now_ge_next;
        state_nxt       = S_EVAL;
      end
      // Pick end of blink, closing ramp or opening ramp
      S_EVAL: begin
        if (!sts.active) begin
          cmd.lid_zero = 1'b1;
          state_nxt    = S_OUT;
        end else if (sts.t_ge_2half) begin
          cmd.div_hash = 1'b1;
          state_nxt    = S_END;
        end else if (sts.t_le_half) begin
          cmd.div_up = 1'b1;
          state_nxt  = S_RAMP;
        end else begin
          cmd.div_down = 1'b1;
          state_nxt    = S_RAMP;
        end
      end
      S_END: begin
        if (sts.div_done) begin
          cmd.end_blink = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_RAMP: begin
        if (sts.div_done) begin
          cmd.lid_wr = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      // Hand the result over once the output register is free
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_wr = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/blink_scheduler_lid_ramp.sv]
// Eyelid blink scheduler with lid ramp: top level with register file and stream ports.
// A trigger beat needs no division; an update tick uses the shared divider once or not at all,
// and twice when the first tick also schedules. Beats are handled one at a time, and the
// 32-step divider takes most of the time of a beat that uses it.
// A new beat is taken as soon as the previous result sits in the output register.
// Reset (synchronous, active low) clears blink state and schedule and reloads the registers.
module blink_scheduler_lid_ramp (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] now_ms
  input  logic        in_tuser,   // [0] req_type
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] lid_pos, [10] lid_changed, [11] blinking, zero pad
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import bslr_pkg::*;

  logic [15:0] base_r;
  logic [15:0] spread_r;
  logic [9:0]  half_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  bslr_cmd_t   cmd;
  bslr_sts_t   sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  // Write the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_RESET;
      spread_r <= SPREAD_RESET;
      half_r   <= HALF_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BASE:   base_r   <= cfg_pwdata[15:0];
        REG_SPREAD: spread_r <= cfg_pwdata[15:0];
        REG_HALF:   half_r   <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      REG_BASE:   cfg_prdata = {16'd0, base_r};
      REG_SPREAD: cfg_prdata = {16'd0, spread_r};
      REG_HALF:   cfg_prdata = {22'd0, half_r};
      default:    cfg_prdata = '0;
    endcase
  end

  bslr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bslr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_req     (in_tuser),
    .in_now     (in_tdata),
    .cfg_base   (base_r),
    .cfg_spread (spread_r),
    .cfg_half   (half_r),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata)
  );

  // Lid never reported beyond full travel
  a_lid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[9:0] <= 10'(FULL_SCALE)))
    else $error("lid position beyond full scale");

  // Lid open whenever no blink runs
  a_open_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[11]) |-> (out_tdata[9:0] == 10'd0))
    else $error("lid not open outside a blink");

  // One beat at a time
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("beat accepted while another is in flight");

  // A lid move outside a blink can only be the return to open
  a_ramp_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[10]) |-> (out_tdata[11] || out_tdata[9:0] == 10'd0))
    else $error("lid moved outside a blink");

endmodule
